[design/slrr_pkg.sv]
// shared widths and status type for the slope limited linear reconstruction block
// no dependencies; used by the serial units and the top level
package slrr_pkg;

  // cell value width
  localparam int unsigned SAMPLE_BITS = 32;
  // neighbour difference and its magnitude
  localparam int unsigned MAG_BITS    = SAMPLE_BITS + 1;
  // sum of two magnitudes, divisor of the harmonic mean
  localparam int unsigned SUM_BITS    = MAG_BITS + 1;
  // full product of two magnitudes
  localparam int unsigned PROD_BITS   = 2 * MAG_BITS;
  // step counter of the serial units, one step per magnitude bit
  localparam int unsigned STEP_BITS   = $clog2(MAG_BITS);
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(MAG_BITS - 1);

  localparam logic MODE_VAN_LEER = 1'b0;
  localparam logic MODE_MC       = 1'b1;

  // handshake status of a serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

[design/slrr_mul.sv]
// bit-serial shift-add multiplier for two magnitudes, one multiplier bit per cycle
// depends on slrr_pkg
module slrr_mul (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [slrr_pkg::MAG_BITS-1:0]   mcand_i,
  input  logic [slrr_pkg::MAG_BITS-1:0]   mplier_i,
  output logic [slrr_pkg::PROD_BITS-1:0]  prod_o,
  output slrr_pkg::unit_sts_t             sts_o
);

  logic [slrr_pkg::MAG_BITS-1:0]  mcand_q;
  logic [slrr_pkg::SUM_BITS-1:0]  acc_q;
  logic [slrr_pkg::MAG_BITS-1:0]  plier_q;
  logic [slrr_pkg::STEP_BITS-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;
  logic [slrr_pkg::SUM_BITS-1:0]  sum;

  // partial sum of this step
  assign sum = acc_q + (plier_q[0] ? {1'b0, mcand_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == slrr_pkg::LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      plier_q <= mplier_i;
      acc_q   <= '0;
    end else if (busy_q) begin
      // shift the product right, lsb of the sum drops into the multiplier word
      {acc_q, plier_q} <= {1'b0, sum, plier_q[slrr_pkg::MAG_BITS-1:1]};
    end
  end

  assign prod_o = slrr_pkg::PROD_BITS'({acc_q, plier_q});
  assign sts_o  = '{busy: busy_q, done: done_q};

endmodule

[design/slrr_div.sv]
// restoring bit-serial divider, one quotient bit per cycle
// depends on slrr_pkg; the quotient must fit in MAG_BITS bits
module slrr_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [slrr_pkg::PROD_BITS-1:0]  dividend_i,
  input  logic [slrr_pkg::SUM_BITS-1:0]   divisor_i,
  output logic [slrr_pkg::MAG_BITS-1:0]   quot_o,
  output slrr_pkg::unit_sts_t             sts_o
);

  logic [slrr_pkg::SUM_BITS-1:0]  dvs_q;
  logic [slrr_pkg::SUM_BITS-1:0]  rem_q;
  logic [slrr_pkg::MAG_BITS-1:0]  quot_q;
  logic [slrr_pkg::STEP_BITS-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;
  logic [slrr_pkg::SUM_BITS:0]    trial;
  logic [slrr_pkg::SUM_BITS:0]    diff;
  logic                           ge;

  // bring down the next dividend bit and try the subtraction
  assign trial = {rem_q, quot_q[slrr_pkg::MAG_BITS-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == slrr_pkg::LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q  <= divisor_i;
      // upper part is below the divisor since the quotient fits
      rem_q  <= slrr_pkg::SUM_BITS'(dividend_i[slrr_pkg::PROD_BITS-1:slrr_pkg::MAG_BITS]);
      quot_q <= dividend_i[slrr_pkg::MAG_BITS-1:0];
    end else if (busy_q) begin
      rem_q  <= ge ? diff[slrr_pkg::SUM_BITS-1:0] : trial[slrr_pkg::SUM_BITS-1:0];
      quot_q <= {quot_q[slrr_pkg::MAG_BITS-2:0], ge};
    end
  end

  assign quot_o = quot_q;
  assign sts_o  = '{busy: busy_q, done: done_q};

endmodule

[design/slope_limited_linear_reconstruction_top.sv]
// top level of the slope limited linear reconstruction block: window, sequencer, output register
// depends on slrr_pkg, slrr_mul and slrr_div
//
//  channel   direction  tdata                                tuser
//  s_axis    in         [31:0] sample                        [0] line_start
//  m_axis    out        [31:0] face_plus, [63:32] face_minus [0] valid_res
//  cfg       in         cfg_wdata_i = limiter_mode, written when cfg_we_i is high
//
//  one transaction in gives one transaction out; a new sample is taken only when the
//  sequencer is idle
//  van Leer: the sample passes through the 33-step serial multiplier and then the
//  33-step serial divider, which run one after the other
//  monotonized central and a window not yet full skip both serial units
//  a finished result waits in the output register, the next sample can enter meanwhile
//  reset clears the window, the fill count, the mode and the output valid
module slope_limited_linear_reconstruction_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] sample
  input  logic [0:0]  s_axis_tuser_i,   // [0] line_start
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [31:0] face_plus, [63:32] face_minus
  output logic [0:0]  m_axis_tuser_o    // [0] valid_res
);

  localparam int unsigned SW = slrr_pkg::SAMPLE_BITS;
  localparam int unsigned MW = slrr_pkg::MAG_BITS;
  localparam int unsigned UW = slrr_pkg::SUM_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MAG,
    ST_SUM,
    ST_MC,
    ST_MUL,
    ST_DIV,
    ST_FACE
  } state_e;

  state_e           state_q;
  logic             mode_q;
  logic [1:0]       fill_q;
  logic [SW-1:0]    older_q;
  logic [SW-1:0]    centre_q;
  // working copy of the window for the item in flight
  logic [SW-1:0]    win_new_q;
  logic [SW-1:0]    win_cen_q;
  logic [SW-1:0]    win_old_q;
  logic             valid_q;
  logic [MW-1:0]    a_q;
  logic [MW-1:0]    b_q;
  logic [MW-1:0]    ma_q;
  logic [MW-1:0]    mb_q;
  logic             neg_q;
  logic             nz_q;
  logic [UW-1:0]    sum_q;
  logic [MW-1:0]    min_ab_q;
  logic [MW-1:0]    hmag_q;
  logic             out_valid_q;
  logic [SW-1:0]    out_plus_q;
  logic [SW-1:0]    out_minus_q;
  logic             out_flag_q;

  logic             in_fire;
  logic             out_free;
  logic             load_out;
  logic             mul_start;
  logic             div_start;
  logic [slrr_pkg::PROD_BITS-1:0] mul_prod;
  logic [MW-1:0]    div_quot;
  slrr_pkg::unit_sts_t mul_sts;
  slrr_pkg::unit_sts_t div_sts;

  logic [MW-1:0]    a_abs;
  logic [MW-1:0]    b_abs;
  logic [MW-1:0]    quarter;
  logic [MW-1:0]    cen_ext;
  logic [MW-1:0]    up_face;
  logic [MW-1:0]    dn_face;

  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  // face stage hands its result to the output register
  assign load_out        = (state_q == ST_FACE) && out_free;

  assign mul_start = (state_q == ST_SUM) && valid_q && nz_q &&
                     (mode_q == slrr_pkg::MODE_VAN_LEER);
  assign div_start = (state_q == ST_MUL) && mul_sts.done;

  // magnitudes of the neighbour differences
  assign a_abs   = a_q[MW-1] ? (MW'(0) - a_q) : a_q;
  assign b_abs   = b_q[MW-1] ? (MW'(0) - b_q) : b_q;
  // quarter of the summed magnitudes, half of the mean slope term
  assign quarter = MW'(sum_q >> 2);

  // faces: centre moved up and down by the half slope
  assign cen_ext = {win_cen_q[SW-1], win_cen_q};
  assign up_face = neg_q ? (cen_ext - hmag_q) : (cen_ext + hmag_q);
  assign dn_face = neg_q ? (cen_ext + hmag_q) : (cen_ext - hmag_q);

  slrr_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mb_q),
    .mplier_i (ma_q),
    .prod_o   (mul_prod),
    .sts_o    (mul_sts)
  );

  slrr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_prod),
    .divisor_i  (sum_q),
    .quot_o     (div_quot),
    .sts_o      (div_sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= slrr_pkg::MODE_VAN_LEER;
      fill_q      <= '0;
      older_q     <= '0;
      centre_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            // line start empties the window before this sample enters
            win_new_q <= s_axis_tdata_i;
            win_cen_q <= s_axis_tuser_i[0] ? '0 : centre_q;
            win_old_q <= s_axis_tuser_i[0] ? '0 : older_q;
            valid_q   <= !s_axis_tuser_i[0] && (fill_q == 2'd2);
            older_q   <= s_axis_tuser_i[0] ? '0 : centre_q;
            centre_q  <= s_axis_tdata_i;
            if (s_axis_tuser_i[0]) begin
              fill_q <= 2'd1;
            end else if (fill_q != 2'd2) begin
              fill_q <= fill_q + 2'd1;
            end
            state_q <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          // backward and forward differences
          a_q     <= {win_cen_q[SW-1], win_cen_q} - {win_old_q[SW-1], win_old_q};
          b_q     <= {win_new_q[SW-1], win_new_q} - {win_cen_q[SW-1], win_cen_q};
          state_q <= ST_MAG;
        end
        ST_MAG: begin
          ma_q   <= a_abs;
          mb_q   <= b_abs;
          neg_q  <= a_q[MW-1];
          nz_q   <= (a_q != '0) && (b_q != '0) && (a_q[MW-1] == b_q[MW-1]);
          hmag_q <= '0;
          if (!valid_q || a_q == '0 || b_q == '0 || a_q[MW-1] != b_q[MW-1]) begin
            state_q <= ST_FACE;
          end else begin
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          sum_q    <= {1'b0, ma_q} + {1'b0, mb_q};
          min_ab_q <= (ma_q < mb_q) ? ma_q : mb_q;
          if (mode_q == slrr_pkg::MODE_MC) begin
            state_q <= ST_MC;
          end else begin
            state_q <= ST_MUL;
          end
        end
        ST_MC: begin
          hmag_q  <= (quarter < min_ab_q) ? quarter : min_ab_q;
          state_q <= ST_FACE;
        end
        ST_MUL: begin
          if (mul_sts.done) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_sts.done) begin
            hmag_q  <= div_quot;
            state_q <= ST_FACE;
          end
        end
        ST_FACE: begin
          if (out_free) begin
            out_plus_q  <= valid_q ? up_face[SW-1:0] : '0;
            out_minus_q <= valid_q ? dn_face[SW-1:0] : '0;
            out_flag_q  <= valid_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_minus_q, out_plus_q};
  assign m_axis_tuser_o  = out_flag_q;

`ifndef SYNTHESIS
  // serial units are quiet whenever a new sample may enter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (!mul_sts.busy && !div_sts.busy))
    else $error("serial unit busy while sequencer idle");

  // the output register is loaded only from the face stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_FACE))
    else $error("result loaded outside face stage");

  // the limited half slope never exceeds the smaller neighbour difference
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FACE && hmag_q != '0) |-> (hmag_q <= min_ab_q))
    else $error("half slope above smaller difference");

  // the divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == ST_DIV))
    else $error("divider done outside divide stage");
`endif

endmodule
